// ----- design/tsp_pkg.sv -----
// Package for the tar stream parser: field widths, header layout positions,
// role and entry-kind codes, and the ustar magic lookup.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int BLOCK_BYTES      = 512;
  localparam int SIZE_FIELD_BYTES = 12;

  localparam int BYTE_W  = 8;
  localparam int OFS_W   = $clog2(BLOCK_BYTES);
  localparam int SIZE_W  = 36;
  localparam int CHK_W   = 24;
  localparam int SUM_W   = 18;
  localparam int CODE_W  = 3;

  // Header layout
  localparam int POS_SIZE  = 124;
  localparam int POS_CHK   = 148;
  localparam int LEN_CHK   = 8;
  localparam int POS_TYPE  = 156;
  localparam int POS_MAGIC = 257;
  localparam int LEN_MAGIC = 5;

  // Characters
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [BYTE_W-1:0] CH_DIR   = 8'h35;
  localparam logic [BYTE_W-1:0] CH_LONG  = 8'h4C;

  typedef enum logic [CODE_W-1:0] {
    ROLE_HEADER   = 3'd0,
    ROLE_LONGNAME = 3'd1,
    ROLE_DATA     = 3'd2,
    ROLE_PAD      = 3'd3,
    ROLE_END      = 3'd4
  } role_t;

  typedef enum logic [CODE_W-1:0] {
    KIND_REGULAR = 3'd0,
    KIND_DIR     = 3'd1,
    KIND_LONG    = 3'd2,
    KIND_OTHER   = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  // Expected character of the ustar magic at a given index
  function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h75; // u
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h72; // r
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- design/tsp_in_if.sv -----
// Input channel of the tar stream parser: one archive byte per beat.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

interface tsp_in_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- design/tsp_out_if.sv -----
// Result channel of the tar stream parser: tagged byte plus header facts.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

interface tsp_out_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic [CODE_W-1:0] role;
  logic [OFS_W-1:0]  block_offset;
  logic              header_done;
  logic [CODE_W-1:0] entry_kind;
  logic [SIZE_W-1:0] entry_size;
  logic              checksum_ok;
  logic              is_ustar;
  logic              last_data;
  logic              format_error;

  modport source (output valid, output byte_out, output role, output block_offset,
                  output header_done, output entry_kind, output entry_size,
                  output checksum_ok, output is_ustar, output last_data,
                  output format_error, input ready);
  modport sink   (input valid, input byte_out, input role, input block_offset,
                  input header_done, input entry_kind, input entry_size,
                  input checksum_ok, input is_ustar, input last_data,
                  input format_error, output ready);
endinterface

// ----- design/tar_stream_parser.sv -----
// Tar stream parser: one byte in, one tagged result beat out.
// An input register holds each byte and a result register holds its tagged beat.
// One byte per cycle while the result side takes beats; the per-byte counters and header
// accumulators are computed between the two registers and update as each byte moves on.
// Reset (rst_n low, synchronous): both registers empty, parser back to the
// start of a header block with all header accumulators cleared.
`timescale 1ns / 1ps

module tar_stream_parser (
  input  logic          clk,
  input  logic          rst_n,
  tsp_in_if.sink        in_ch,
  tsp_out_if.source     out_ch
);
  import tsp_pkg::*;

  // Pipeline control
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic              adv;
  logic              step;

  // Parser state
  role_t             phase_r,     phase_nxt;
  logic [OFS_W-1:0]  offset_r,    offset_nxt;
  logic [SIZE_W-1:0] data_left_r, data_left_nxt;
  logic [SIZE_W-1:0] size_acc_r,  size_acc_nxt;
  logic              size_end_r,  size_end_nxt;
  logic [CHK_W-1:0]  chk_acc_r,   chk_acc_nxt;
  logic              chk_end_r,   chk_end_nxt;
  logic [SUM_W-1:0]  usum_r,      usum_nxt;
  logic [SUM_W-1:0]  ssum_r,      ssum_nxt;
  logic [BYTE_W-1:0] type_r,      type_nxt;
  logic              magic_r,     magic_nxt;
  logic              zero_r,      zero_nxt;
  logic              derr_r,      derr_nxt;

  // Result of the byte in the input register
  role_t             res_role;
  logic              res_done;
  kind_t             res_kind;
  logic [SIZE_W-1:0] res_size;
  logic              res_ok;
  logic              res_ustar;
  logic              res_last;
  logic              res_ferr;

  // Result register
  logic [BYTE_W-1:0] o_byte_r;
  role_t             o_role_r;
  logic [OFS_W-1:0]  o_ofs_r;
  logic              o_done_r;
  kind_t             o_kind_r;
  logic [SIZE_W-1:0] o_size_r;
  logic              o_ok_r;
  logic              o_ustar_r;
  logic              o_last_r;
  logic              o_ferr_r;

  // Decode helpers
  logic              last_blk;
  logic              in_size, in_chk, at_magic;
  logic              fld_end, fld_oct;
  logic [BYTE_W-1:0] sum_byte;
  logic [2:0]        magic_idx;
  kind_t             kind_c;

  // Handshake: result register moves when empty or taken
  assign adv         = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;

  // Byte classification within the header
  always_comb begin
    last_blk  = (offset_r == OFS_W'(BLOCK_BYTES - 1));
    in_size   = (offset_r >= OFS_W'(POS_SIZE)) &&
                (offset_r <  OFS_W'(POS_SIZE + SIZE_FIELD_BYTES));
    in_chk    = (offset_r >= OFS_W'(POS_CHK)) && (offset_r < OFS_W'(POS_CHK + LEN_CHK));
    at_magic  = (offset_r >= OFS_W'(POS_MAGIC)) &&
                (offset_r <  OFS_W'(POS_MAGIC + LEN_MAGIC));
    magic_idx = 3'(offset_r - OFS_W'(POS_MAGIC));
    fld_end   = (s1_byte_r == CH_NUL) || (s1_byte_r == CH_SPACE);
    fld_oct   = s1_byte_r inside {[CH_ZERO:CH_SEVEN]};
    sum_byte  = in_chk ? CH_SPACE : s1_byte_r;
  end

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt     = phase_r;
    data_left_nxt = data_left_r;
    size_acc_nxt  = size_acc_r;
    size_end_nxt  = size_end_r;
    chk_acc_nxt   = chk_acc_r;
    chk_end_nxt   = chk_end_r;
    usum_nxt      = usum_r;
    ssum_nxt      = ssum_r;
    type_nxt      = type_r;
    magic_nxt     = magic_r;
    zero_nxt      = zero_r;
    derr_nxt      = derr_r;
    offset_nxt    = last_blk ? '0 : offset_r + 1'b1;
    kind_c        = KIND_OTHER;

    res_role  = phase_r;
    res_done  = 1'b0;
    res_kind  = KIND_REGULAR;
    res_size  = '0;
    res_ok    = 1'b0;
    res_ustar = 1'b0;
    res_last  = 1'b0;
    res_ferr  = 1'b0;

    case (phase_r)
      ROLE_HEADER: begin
        zero_nxt = zero_r && (s1_byte_r == CH_NUL);

        // Octal size field
        if (in_size && !size_end_r) begin
          if (fld_end) begin
            size_end_nxt = 1'b1;
          end else if (fld_oct) begin
            size_acc_nxt = {size_acc_r[SIZE_W-4:0], s1_byte_r[2:0]};
          end else begin
            derr_nxt = 1'b1;
          end
        end

        // Octal checksum field
        if (in_chk && !chk_end_r) begin
          if (fld_end) begin
            chk_end_nxt = 1'b1;
          end else if (fld_oct) begin
            chk_acc_nxt = {chk_acc_r[CHK_W-4:0], s1_byte_r[2:0]};
          end else begin
            derr_nxt = 1'b1;
          end
        end

        // Running sums, checksum field counted as spaces
        usum_nxt = usum_r + {{(SUM_W-BYTE_W){1'b0}}, sum_byte};
        ssum_nxt = ssum_r + {{(SUM_W-BYTE_W){sum_byte[BYTE_W-1]}}, sum_byte};

        if (offset_r == OFS_W'(POS_TYPE)) begin
          type_nxt = s1_byte_r;
        end
        if (at_magic && (s1_byte_r != magic_char(magic_idx))) begin
          magic_nxt = 1'b0;
        end

        // Block end: report the header and choose what follows
        if (last_blk) begin
          if (zero_nxt) begin
            kind_c = KIND_END;
          end else if ((type_r == CH_ZERO) || (type_r == CH_NUL)) begin
            kind_c = KIND_REGULAR;
          end else if (type_r == CH_DIR) begin
            kind_c = KIND_DIR;
          end else if (type_r == CH_LONG) begin
            kind_c = KIND_LONG;
          end else begin
            kind_c = KIND_OTHER;
          end

          res_done  = 1'b1;
          res_kind  = kind_c;
          res_size  = size_acc_r;
          res_ok    = (chk_acc_r == CHK_W'(usum_nxt)) ||
                      (!ssum_nxt[SUM_W-1] && (chk_acc_r == CHK_W'(ssum_nxt)));
          res_ustar = magic_r;
          res_ferr  = derr_r;

          case (kind_c)
            KIND_END:  phase_nxt = ROLE_END;
            KIND_LONG: phase_nxt = ROLE_LONGNAME;
            KIND_REGULAR: begin
              if (size_acc_r != '0) begin
                data_left_nxt = size_acc_r;
                phase_nxt     = ROLE_DATA;
              end else begin
                phase_nxt = ROLE_HEADER;
              end
            end
            default:   phase_nxt = ROLE_HEADER;
          endcase

          // Clear header accumulators for the next header
          size_acc_nxt = '0;
          size_end_nxt = 1'b0;
          chk_acc_nxt  = '0;
          chk_end_nxt  = 1'b0;
          usum_nxt     = '0;
          ssum_nxt     = '0;
          type_nxt     = '0;
          magic_nxt    = 1'b1;
          zero_nxt     = 1'b1;
          derr_nxt     = 1'b0;
        end
      end

      ROLE_LONGNAME, ROLE_PAD: begin
        if (last_blk) begin
          phase_nxt = ROLE_HEADER;
        end
      end

      ROLE_DATA: begin
        if (data_left_r != '0) begin
          data_left_nxt = data_left_r - 1'b1;
        end
        if (data_left_nxt == '0) begin
          res_last  = 1'b1;
          phase_nxt = last_blk ? ROLE_HEADER : ROLE_PAD;
        end
      end

      default: begin
        phase_nxt = ROLE_END;
        res_role  = ROLE_END;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= ROLE_HEADER;
      offset_r    <= '0;
      data_left_r <= '0;
      size_acc_r  <= '0;
      size_end_r  <= 1'b0;
      chk_acc_r   <= '0;
      chk_end_r   <= 1'b0;
      usum_r      <= '0;
      ssum_r      <= '0;
      type_r      <= '0;
      magic_r     <= 1'b1;
      zero_r      <= 1'b1;
      derr_r      <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        offset_r    <= offset_nxt;
        data_left_r <= data_left_nxt;
        size_acc_r  <= size_acc_nxt;
        size_end_r  <= size_end_nxt;
        chk_acc_r   <= chk_acc_nxt;
        chk_end_r   <= chk_end_nxt;
        usum_r      <= usum_nxt;
        ssum_r      <= ssum_nxt;
        type_r      <= type_nxt;
        magic_r     <= magic_nxt;
        zero_r      <= zero_nxt;
        derr_r      <= derr_nxt;
      end
    end
  end

  // Payload registers: capture input beat, then the tagged result
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_in;
    end
    if (step) begin
      o_byte_r  <= s1_byte_r;
      o_role_r  <= res_role;
      o_ofs_r   <= offset_r;
      o_done_r  <= res_done;
      o_kind_r  <= res_kind;
      o_size_r  <= res_size;
      o_ok_r    <= res_ok;
      o_ustar_r <= res_ustar;
      o_last_r  <= res_last;
      o_ferr_r  <= res_ferr;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_out     = o_byte_r;
  assign out_ch.role         = o_role_r;
  assign out_ch.block_offset = o_ofs_r;
  assign out_ch.header_done  = o_done_r;
  assign out_ch.entry_kind   = o_kind_r;
  assign out_ch.entry_size   = o_size_r;
  assign out_ch.checksum_ok  = o_ok_r;
  assign out_ch.is_ustar     = o_ustar_r;
  assign out_ch.last_data    = o_last_r;
  assign out_ch.format_error = o_ferr_r;

endmodule

// ----- design/tsp_checker.sv -----
// Port-level checks for the tar stream parser, bound to tar_stream_parser.
// Depends on tsp_pkg and tar_stream_parser.
`timescale 1ns / 1ps

module tsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tsp_pkg::BYTE_W-1:0]  byte_out,
  input logic [tsp_pkg::CODE_W-1:0]  role,
  input logic [tsp_pkg::OFS_W-1:0]   block_offset,
  input logic                        header_done,
  input logic [tsp_pkg::CODE_W-1:0]  entry_kind,
  input logic [tsp_pkg::SIZE_W-1:0]  entry_size,
  input logic                        checksum_ok,
  input logic                        is_ustar,
  input logic                        last_data,
  input logic                        format_error
);
  import tsp_pkg::*;

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(role) &&
      $stable(block_offset) && $stable(header_done))
    else $error("result beat changed while stalled");

  // Header report only on the last byte of a header block
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && header_done |->
      role == ROLE_HEADER && block_offset == OFS_W'(BLOCK_BYTES - 1))
    else $error("header_done outside last header byte");

  // Header facts stay zero away from the header report
  a_facts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !header_done |->
      entry_kind == '0 && entry_size == '0 && !checksum_ok && !is_ustar && !format_error)
    else $error("header facts nonzero without header_done");

  // Last data byte only while tagged as file data
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_data |-> role == ROLE_DATA && !header_done)
    else $error("last_data outside file data");

endmodule

bind tar_stream_parser tsp_checker u_tsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .byte_out     (out_ch.byte_out),
  .role         (out_ch.role),
  .block_offset (out_ch.block_offset),
  .header_done  (out_ch.header_done),
  .entry_kind   (out_ch.entry_kind),
  .entry_size   (out_ch.entry_size),
  .checksum_ok  (out_ch.checksum_ok),
  .is_ustar     (out_ch.is_ustar),
  .last_data    (out_ch.last_data),
  .format_error (out_ch.format_error)
);

// ----- bench/testbench.sv -----
// Self-checking bench for tar_stream_parser: streams tar archives byte by byte
// and compares every tagged result beat against a byte-level parser model.
// Depends on tsp_pkg, tsp_in_if, tsp_out_if and the tar_stream_parser RTL.
`timescale 1ns / 1ps

module testbench;
  import tsp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_BYTES   = 1900;
  localparam int IDLE_LIMIT     = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int DIRECTED_CASES = 10;

  localparam logic [8*LEN_MAGIC-1:0] USTAR_TXT = "ustar";
  localparam logic [BYTE_W-1:0]      CH_OTHER  = 8'h78;

  // One result beat as the parser reports it
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    role_t             role;
    logic [OFS_W-1:0]  ofs;
    logic              done;
    kind_t             kind;
    logic [SIZE_W-1:0] size;
    logic              ok;
    logic              ustar;
    logic              last;
    logic              ferr;
  } tag_t;

  // How the checksum field of a generated header is filled
  typedef enum int {
    CHK_UNSIGNED,
    CHK_WIDE,
    CHK_SIGNED,
    CHK_BAD,
    CHK_BLANK,
    CHK_JUNK
  } chk_mode_t;

  // Byte-level parser model plus the queue of tags still due from the block
  class tar_tag_model;
    role_t             phase;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] data_left;
    logic [SIZE_W-1:0] size_acc;
    logic              size_end;
    logic [CHK_W-1:0]  chk_acc;
    logic              chk_end;
    logic [SUM_W-1:0]  usum;
    logic [SUM_W-1:0]  ssum;
    logic [BYTE_W-1:0] type_b;
    logic              magic_ok;
    logic              zero_hdr;
    logic              bad_digit;
    tag_t              tags_due[$];
    int unsigned       mismatches;

    function new();
      phase      = ROLE_HEADER;
      ofs        = '0;
      data_left  = '0;
      mismatches = 0;
      clear_header();
    endfunction

    function void clear_header();
      size_acc  = '0;
      size_end  = 1'b0;
      chk_acc   = '0;
      chk_end   = 1'b0;
      usum      = '0;
      ssum      = '0;
      type_b    = '0;
      magic_ok  = 1'b1;
      zero_hdr  = 1'b1;
      bad_digit = 1'b0;
    endfunction

    // Shift one octal digit in; stop at NUL or space, flag anything else
    function void octal_take(inout logic [SIZE_W-1:0] acc, inout logic ended,
                             input logic [BYTE_W-1:0] b);
      if (ended) return;
      if (b == CH_NUL || b == CH_SPACE) begin
        ended = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
        acc = {acc[SIZE_W-4:0], b[2:0]};
      end else begin
        bad_digit = 1'b1;
      end
    endfunction

    function tag_t predict_tag(input logic [BYTE_W-1:0] b);
      tag_t              t;
      logic              last_of_block;
      logic [BYTE_W-1:0] sb;
      logic [SIZE_W-1:0] chk_wide;
      int                k;
      t             = '0;
      t.data        = b;
      t.role        = phase;
      t.ofs         = ofs;
      last_of_block = (ofs == OFS_W'(BLOCK_BYTES - 1));
      case (phase)
        ROLE_HEADER: begin
          sb = b;
          if (b != CH_NUL) zero_hdr = 1'b0;
          if (ofs >= POS_SIZE && ofs < POS_SIZE + SIZE_FIELD_BYTES)
            octal_take(size_acc, size_end, b);
          // checksum field counts as spaces in both sums
          if (ofs >= POS_CHK && ofs < POS_CHK + LEN_CHK) begin
            chk_wide = SIZE_W'(chk_acc);
            octal_take(chk_wide, chk_end, b);
            chk_acc = chk_wide[CHK_W-1:0];
            sb = CH_SPACE;
          end
          usum = usum + SUM_W'(sb);
          ssum = ssum + {{(SUM_W-BYTE_W){sb[BYTE_W-1]}}, sb};
          if (ofs == POS_TYPE) type_b = b;
          if (ofs >= POS_MAGIC && ofs < POS_MAGIC + LEN_MAGIC) begin
            k = int'(ofs) - POS_MAGIC;
            if (b != USTAR_TXT[8*(LEN_MAGIC-1-k) +: 8]) magic_ok = 1'b0;
          end
          // report the header and pick what follows it
          if (last_of_block) begin
            t.done = 1'b1;
            if (zero_hdr) t.kind = KIND_END;
            else if (type_b == CH_ZERO || type_b == CH_NUL) t.kind = KIND_REGULAR;
            else if (type_b == CH_DIR) t.kind = KIND_DIR;
            else if (type_b == CH_LONG) t.kind = KIND_LONG;
            else t.kind = KIND_OTHER;
            t.size  = size_acc;
            t.ok    = (chk_acc == CHK_W'(usum)) ||
                      (!ssum[SUM_W-1] && chk_acc == CHK_W'(ssum));
            t.ustar = magic_ok;
            t.ferr  = bad_digit;
            case (t.kind)
              KIND_END:  phase = ROLE_END;
              KIND_LONG: phase = ROLE_LONGNAME;
              KIND_REGULAR: begin
                if (size_acc != '0) begin
                  data_left = size_acc;
                  phase     = ROLE_DATA;
                end else begin
                  phase = ROLE_HEADER;
                end
              end
              default:   phase = ROLE_HEADER;
            endcase
            clear_header();
          end
        end
        ROLE_LONGNAME: begin
          if (last_of_block) phase = ROLE_HEADER;
        end
        ROLE_DATA: begin
          if (data_left != '0) data_left = data_left - 1'b1;
          if (data_left == '0) begin
            t.last = 1'b1;
            phase  = last_of_block ? ROLE_HEADER : ROLE_PAD;
          end
        end
        ROLE_PAD: begin
          if (last_of_block) phase = ROLE_HEADER;
        end
        default: begin
          phase  = ROLE_END;
          t.role = ROLE_END;
        end
      endcase
      ofs = last_of_block ? '0 : ofs + 1'b1;
      return t;
    endfunction

    function void take_byte(input logic [BYTE_W-1:0] b);
      tags_due.push_back(predict_tag(b));
    endfunction

    function void cmp_field(input string what, input logic [47:0] want,
                            input logic [47:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_tag(input tag_t got);
      tag_t want;
      if (tags_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing due, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = tags_due.pop_front();
      cmp_field("byte_out", 48'(want.data), 48'(got.data));
      cmp_field("role", 48'(want.role), 48'(got.role));
      cmp_field("block_offset", 48'(want.ofs), 48'(got.ofs));
      cmp_field("header_done", 48'(want.done), 48'(got.done));
      cmp_field("entry_kind", 48'(want.kind), 48'(got.kind));
      cmp_field("entry_size", 48'(want.size), 48'(got.size));
      cmp_field("checksum_ok", 48'(want.ok), 48'(got.ok));
      cmp_field("is_ustar", 48'(want.ustar), 48'(got.ustar));
      cmp_field("last_data", 48'(want.last), 48'(got.last));
      cmp_field("format_error", 48'(want.ferr), 48'(got.ferr));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  bit        sink_ready = 1'b0;
  bit        in_quiet;
  bit        out_quiet;
  int        out_stall;
  int        bytes_sent;
  int        idle_cycles;

  logic [BYTE_W-1:0] blk [BLOCK_BYTES];
  tar_tag_model      tracker;

  tsp_in_if  in_ch ();
  tsp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  tar_stream_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Gap length: mostly short, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random, with quiet stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 999) < 3) out_quiet = !out_quiet;
    if (out_stall > 0) begin
      out_stall--;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      if (!out_quiet && $urandom_range(0, 99) < 20) out_stall = pick_gap();
    end
  end

  // Track every beat on both channels; watch for a stuck block
  always @(posedge clk) begin
    tag_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.take_byte(in_ch.byte_in);
      if (out_ch.valid && out_ch.ready) begin
        got.data  = out_ch.byte_out;
        got.role  = role_t'(out_ch.role);
        got.ofs   = out_ch.block_offset;
        got.done  = out_ch.header_done;
        got.kind  = kind_t'(out_ch.entry_kind);
        got.size  = out_ch.entry_size;
        got.ok    = out_ch.checksum_ok;
        got.ustar = out_ch.is_ustar;
        got.last  = out_ch.last_data;
        got.ferr  = out_ch.format_error;
        tracker.check_tag(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Drive one byte beat; called and returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int g;
    g = (!in_quiet && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_block();
    in_quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < BLOCK_BYTES; i++) send_byte(blk[i]);
  endtask

  // Hold off the sender until every due tag has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.tags_due.size() != 0);
  endtask

  task automatic put_text(input int pos, input string s);
    for (int i = 0; i < s.len(); i++) blk[pos+i] = s[i];
  endtask

  task automatic put_octal(input int pos, input logic [47:0] val, input int n);
    for (int i = 0; i < n; i++)
      blk[pos+i] = CH_ZERO + BYTE_W'((val >> (3 * (n - 1 - i))) & 48'd7);
  endtask

  // Fill blk with a header; field contents steer the special cases
  task automatic build_header(input logic [BYTE_W-1:0] typ, input logic [47:0] size,
                              input int digits, input logic [BYTE_W-1:0] term,
                              input bit bad_size, input bit magic,
                              input chk_mode_t chk, input int high_cnt);
    int name_len;
    int u;
    int s;
    int v;
    name_len = $urandom_range(1, 99);
    for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = CH_NUL;
    for (int i = 0; i < name_len; i++) blk[i] = BYTE_W'($urandom_range(8'h21, 8'h7e));
    if (high_cnt >= 100) begin
      for (int i = 0; i < 100; i++) blk[i] = BYTE_W'($urandom_range(8'h80, 8'h8f));
    end else begin
      for (int i = 0; i < high_cnt; i++)
        blk[$urandom_range(0, 99)] = BYTE_W'($urandom_range(128, 255));
    end
    put_text(100, "0000644");
    put_text(108, "0001750");
    put_text(116, "0001750");
    put_text(136, "14571234567");
    // size digits may run past the field into mtime
    put_octal(POS_SIZE, size, digits);
    if (digits < SIZE_FIELD_BYTES) blk[POS_SIZE+digits] = term;
    if (bad_size)
      blk[POS_SIZE + $urandom_range(0, (digits > 0) ? digits - 1 : 0)] =
        BYTE_W'($urandom_range(8'h38, 8'hff));
    blk[POS_TYPE] = typ;
    put_text(POS_MAGIC, "ustar");
    put_text(POS_MAGIC + 6, "00");
    put_text(265, "user");
    if (!magic) begin
      v = POS_MAGIC + $urandom_range(0, LEN_MAGIC - 1);
      blk[v] = blk[v] + 8'd1;
    end
    // sums with the checksum field taken as spaces
    u = 0;
    s = 0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      v = (i >= POS_CHK && i < POS_CHK + LEN_CHK) ? int'(CH_SPACE) : int'(blk[i]);
      u += v;
      s += (v >= 128) ? v - 256 : v;
    end
    for (int i = 0; i < LEN_CHK; i++) blk[POS_CHK+i] = CH_SPACE;
    case (chk)
      CHK_UNSIGNED: put_octal(POS_CHK, 48'(u), 6);
      CHK_WIDE:     put_octal(POS_CHK, 48'(u), LEN_CHK);
      CHK_SIGNED:   put_octal(POS_CHK, 48'(s & 'h3ffff), 6);
      CHK_BAD:      put_octal(POS_CHK, 48'(u + 1), 6);
      CHK_JUNK: begin
        put_octal(POS_CHK, 48'(u), 6);
        blk[POS_CHK + $urandom_range(0, 5)] = 8'h39;
      end
      default: ;
    endcase
    if (chk != CHK_WIDE && chk != CHK_BLANK) blk[POS_CHK+6] = CH_NUL;
  endtask

  // Send whatever blocks the last header calls for: name block or data and pad
  task automatic send_body();
    int  n;
    bit  pad_rand;
    while (tracker.phase == ROLE_LONGNAME || tracker.phase == ROLE_DATA) begin
      pad_rand = ($urandom_range(0, 3) == 0);
      n = BLOCK_BYTES;
      if (tracker.phase == ROLE_DATA && tracker.data_left < BLOCK_BYTES)
        n = int'(tracker.data_left);
      for (int i = 0; i < BLOCK_BYTES; i++)
        blk[i] = (i < n || pad_rand) ? BYTE_W'($urandom_range(0, 255)) : CH_NUL;
      send_block();
    end
  endtask

  task automatic send_entry();
    send_block();
    send_body();
  endtask

  // Hand-built entries, each aimed at one special case
  task automatic directed_entry(input int which);
    case (which)
      0: begin
        // regular file with a short body
        build_header(CH_ZERO, 5, 11, CH_NUL, 0, 1, CHK_UNSIGNED, 0);
      end
      1: begin
        // NUL type, size of exactly one block, space terminator, 8-digit checksum
        build_header(CH_NUL, 512, 11, CH_SPACE, 0, 1, CHK_WIDE, 0);
      end
      2: begin
        // empty regular file without the ustar magic
        build_header(CH_ZERO, 0, 11, CH_NUL, 0, 0, CHK_UNSIGNED, 0);
      end
      3: begin
        // directory with a non-octal size digit and a wrong checksum
        build_header(CH_DIR, 'o1234567, 7, CH_SPACE, 1, 1, CHK_BAD, 0);
      end
      4: begin
        // long name entry, checksum matching only the signed sum
        build_header(CH_LONG, 100, 11, CH_NUL, 0, 1, CHK_SIGNED, 3);
      end
      5: begin
        // leading space in size: decodes as zero; blank checksum
        build_header(CH_ZERO, 300, 0, CH_SPACE, 0, 1, CHK_BLANK, 0);
      end
      6: begin
        // other type, thirteen sevens: only the size field is read
        build_header(CH_OTHER, '1, 13, CH_NUL, 0, 1, CHK_UNSIGNED, 0);
      end
      7: begin
        // near-empty block: one nonzero byte is not an end marker
        for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = CH_NUL;
        blk[BLOCK_BYTES-1] = 8'h01;
      end
      8: begin
        // negative signed sum must never match
        build_header(CH_DIR, 0, 11, CH_NUL, 0, 1, CHK_SIGNED, 100);
      end
      default: begin
        // full 12-digit size without terminator, junk in checksum, two data blocks
        build_header(CH_ZERO, 513, 12, CH_NUL, 0, 1, CHK_JUNK, 0);
      end
    endcase
    send_entry();
  endtask

  // Random entry: mostly well formed, some noise and some corrupted headers
  task automatic random_entry();
    logic [BYTE_W-1:0] typ;
    logic [47:0]       size;
    int                digits;
    int                sel;
    int                pos;
    bit                is_reg;
    chk_mode_t         chk;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      // noise header with a small, readable size
      for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = BYTE_W'($urandom_range(0, 255));
      put_octal(POS_SIZE, 48'($urandom_range(0, 300)), SIZE_FIELD_BYTES - 1);
      blk[POS_SIZE+SIZE_FIELD_BYTES-1] = $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
      send_entry();
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: typ = CH_ZERO;
      4:          typ = CH_NUL;
      5, 6:       typ = CH_DIR;
      7:          typ = CH_LONG;
      default:    typ = BYTE_W'($urandom_range(0, 255));
    endcase
    is_reg = (typ == CH_ZERO || typ == CH_NUL);
    if (is_reg) begin
      size   = 48'(($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 4) == 0) ? 1100 : 120));
      digits = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 13) : 11;
      if ($urandom_range(0, 19) == 0) digits = 0;
    end else begin
      size   = 48'({$urandom, $urandom});
      digits = $urandom_range(0, 13);
    end
    case ($urandom_range(0, 19))
      0, 1:    chk = CHK_WIDE;
      2, 3:    chk = CHK_SIGNED;
      4, 5:    chk = CHK_BAD;
      6:       chk = CHK_BLANK;
      7, 8:    chk = CHK_JUNK;
      default: chk = CHK_UNSIGNED;
    endcase
    build_header(typ, size, digits, $urandom_range(0, 1) ? CH_SPACE : CH_NUL,
                 $urandom_range(0, 9) == 0, $urandom_range(0, 4) != 0, chk,
                 (chk == CHK_SIGNED) ? $urandom_range(1, 6) : $urandom_range(0, 1));
    // corrupt a few bytes outside the size and type fields
    if (sel < 30) begin
      repeat ($urandom_range(1, 4)) begin
        pos = $urandom_range(0, BLOCK_BYTES - 1);
        if (!(pos >= POS_SIZE && pos < POS_SIZE + SIZE_FIELD_BYTES) && pos != POS_TYPE)
          blk[pos] = BYTE_W'($urandom_range(0, 255));
      end
    end
    send_entry();
  endtask

  initial begin
    int pick;
    tracker       = new();
    in_quiet      = 1'b0;
    out_quiet     = 1'b0;
    out_stall     = 0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    in_ch.valid   = 1'b0;
    in_ch.byte_in = '0;
    rst_n         = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // mix of hand-built and random entries, leaving room for the end marker
    while (bytes_sent < RANDOM_BYTES - 2 * BLOCK_BYTES) begin
      pick = $urandom_range(0, 2 * DIRECTED_CASES - 1);
      if (pick < DIRECTED_CASES) directed_entry(pick);
      else random_entry();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();

    // end marker, then trailing bytes tagged as after end
    for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = CH_NUL;
    send_block();
    repeat ($urandom_range(20, 100)) send_byte(BYTE_W'($urandom_range(0, 255)));

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
